[rtl/core/oah_pkg.sv]
// ----------------------------------------------------------------------------
// oah_pkg: shared constants and types for the open-addressed hash insert unit
// Table geometry, field widths, register indexes, probe modes, status codes
// and the request/response bundles of the shared remainder unit.
// ----------------------------------------------------------------------------
package oah_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W       = 31;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 12;

  localparam int DH_PRIME    = 17;
  localparam int DH_W        = $clog2(DH_PRIME + 1);
  localparam int DIV_W       = (SIZE_W > DH_W) ? SIZE_W : DH_W;
  localparam int DIV_CNT_W   = $clog2(KEY_W + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = CFG_IDX_W'(1);

  // probe modes
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

[rtl/core/oah_if.sv]
// ----------------------------------------------------------------------------
// oah_if: valid/ready channels of the hash insert unit
// Key channel in, result channel out.
// ----------------------------------------------------------------------------
interface oah_in_if;
  logic                     valid;
  logic                     ready;
  logic [oah_pkg::KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface oah_out_if;
  logic                        valid;
  logic                        ready;
  logic [oah_pkg::STATUS_W-1:0] status;
  logic [oah_pkg::IDX_W-1:0]    slot;
  logic [oah_pkg::COUNT_W-1:0]  probe_count;
  logic [oah_pkg::SIZE_W-1:0]   entry_count;

  modport source (output valid, output status, output slot, output probe_count,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input slot, input probe_count,
                  input entry_count, output ready);
endinterface

[rtl/core/oah_div.sv]
// ----------------------------------------------------------------------------
// oah_div: shared bit-serial remainder unit
// Restoring remainder, one dividend bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module oah_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oah_pkg::div_req_t req_i,
  output oah_pkg::div_rsp_t rsp_o
);

  logic [oah_pkg::KEY_W-1:0]     dvd_q;
  logic [oah_pkg::DIV_W-1:0]     dvs_q;
  logic [oah_pkg::DIV_W-1:0]     rem_q;
  logic [oah_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                          done_q;

  logic [oah_pkg::DIV_W:0]   trial;
  logic [oah_pkg::DIV_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[oah_pkg::KEY_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      trial = trial - {1'b0, dvs_q};
    end
    rem_d = trial[oah_pkg::DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      dvd_q  <= req_i.dividend;
      dvs_q  <= req_i.divisor;
      rem_q  <= '0;
      cnt_q  <= oah_pkg::DIV_CNT_W'(oah_pkg::KEY_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      rem_q  <= rem_d;
      dvd_q  <= dvd_q << 1;
      cnt_q  <= cnt_q - oah_pkg::DIV_CNT_W'(1);
      done_q <= (cnt_q == oah_pkg::DIV_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

[rtl/core/open_addressing_hash_insert.sv]
// ----------------------------------------------------------------------------
// open_addressing_hash_insert: open-addressed hash table insert unit
// Looks up each nonzero key and stores it if absent; linear, quadratic or double-hash
// probing (or none) over a slot memory with one write and one read port, with one shared remainder unit.
// ----------------------------------------------------------------------------
//   channel   dir  transfer when        payload
//   in_i      in   valid && ready       key
//   out_o     out  valid && ready       status, slot, probe_count, entry_count
//   cfg       in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// An item first finds its home slot (key mod size) on the bit-serial remainder unit,
// then reads and compares that slot; each further probe passes S_NEXT and S_CMP.
// Double-hash mode adds one more remainder pass to find the probe step.
// After reset a clearing pass writes every slot to zero with in_i.ready low.
// A finished result waits in the output register; the next key is taken
// meanwhile, and only completion stalls on a full output register.
// ----------------------------------------------------------------------------
module open_addressing_hash_insert (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [oah_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [oah_pkg::CFG_W-1:0]       cfg_data_i,
  oah_in_if.sink                          in_i,
  oah_out_if.source                       out_o
);

  localparam int TW = oah_pkg::SIZE_W + 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV_HOME, S_DIV_STEP, S_READ, S_CMP, S_NEXT, S_FIN
  } state_e;

  function automatic logic [oah_pkg::SIZE_W-1:0] mod_add(
    input logic [oah_pkg::SIZE_W-1:0] a,
    input logic [oah_pkg::SIZE_W-1:0] b,
    input logic [oah_pkg::SIZE_W-1:0] m
  );
    logic [oah_pkg::SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[oah_pkg::SIZE_W-1:0];
  endfunction

  function automatic logic [oah_pkg::COUNT_W-1:0] sat_count(input logic [TW-1:0] v);
    if (32'(v) > 32'(oah_pkg::COUNT_MAX)) begin
      return oah_pkg::COUNT_MAX;
    end
    return oah_pkg::COUNT_W'(v);
  endfunction

  state_e state_q;

  logic [oah_pkg::MODE_W-1:0]   probe_mode_q;
  logic [oah_pkg::CFG_W-1:0]    table_size_q;

  logic [oah_pkg::KEY_W-1:0]    key_q;
  logic [oah_pkg::IDX_W-1:0]    idx_q;
  logic [oah_pkg::SIZE_W-1:0]   k_q;
  logic [oah_pkg::SIZE_W-1:0]   sq_q;
  logic [oah_pkg::SIZE_W-1:0]   d_q;
  logic [oah_pkg::SIZE_W-1:0]   step_q;
  logic [oah_pkg::SIZE_W-1:0]   occ_q;
  logic [oah_pkg::IDX_W-1:0]    clr_q;

  logic [oah_pkg::STATUS_W-1:0] res_status_q;
  logic [oah_pkg::IDX_W-1:0]    res_slot_q;
  logic [oah_pkg::COUNT_W-1:0]  res_count_q;

  logic                         out_valid_q;
  logic [oah_pkg::STATUS_W-1:0] out_status_q;
  logic [oah_pkg::IDX_W-1:0]    out_slot_q;
  logic [oah_pkg::COUNT_W-1:0]  out_count_q;
  logic [oah_pkg::SIZE_W-1:0]   out_entry_q;

  oah_pkg::div_req_t div_req_q;
  oah_pkg::div_rsp_t div_rsp;

  logic [oah_pkg::KEY_W-1:0] mem_q [oah_pkg::TABLE_DEPTH];
  logic [oah_pkg::KEY_W-1:0] rd_q;
  logic [oah_pkg::IDX_W-1:0] rd_addr;
  logic                      mem_we;
  logic [oah_pkg::IDX_W-1:0] mem_waddr;
  logic [oah_pkg::KEY_W-1:0] mem_wdata;

  logic [oah_pkg::SIZE_W-1:0] eff_size;
  logic [oah_pkg::SIZE_W-1:0] one_m;
  logic [oah_pkg::SIZE_W-1:0] three_m;
  logic [oah_pkg::SIZE_W-1:0] step_sel;
  logic [oah_pkg::IDX_W-1:0]  idx_next;
  logic [9:0]                 m17_sum;
  logic [8:0]                 m17_fold;
  logic [7:0]                 m17_byte;
  logic [oah_pkg::DH_W-1:0]   key_mod17;
  logic [oah_pkg::DH_W-1:0]   dh_step;
  logic [TW-1:0]              k3;
  logic                       hit;
  logic                       empty;
  logic                       out_free;

  oah_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // size in use, clamped to 1..TABLE_DEPTH
  always_comb begin
    if (table_size_q == '0) begin
      eff_size = oah_pkg::SIZE_W'(1);
    end else if (32'(table_size_q) > 32'(oah_pkg::TABLE_DEPTH)) begin
      eff_size = oah_pkg::SIZE_W'(oah_pkg::TABLE_DEPTH);
    end else begin
      eff_size = oah_pkg::SIZE_W'(table_size_q);
    end
  end

  assign one_m   = mod_add('0, oah_pkg::SIZE_W'(1), eff_size);
  assign three_m = mod_add(mod_add(one_m, oah_pkg::SIZE_W'(1), eff_size),
                           oah_pkg::SIZE_W'(1), eff_size);

  always_comb begin
    case (probe_mode_q)
      oah_pkg::MODE_QUAD:   step_sel = sq_q;
      oah_pkg::MODE_DOUBLE: step_sel = step_q;
      default:              step_sel = oah_pkg::SIZE_W'(1);
    endcase
  end

  // key mod 17 by folding: 256 = 1 and 16 = -1 (mod 17)
  always_comb begin
    m17_sum   = 10'(key_q[7:0]) + 10'(key_q[15:8]) + 10'(key_q[23:16]) +
                10'(key_q[30:24]);
    m17_fold  = 9'(m17_sum[9:8]) + 9'(m17_sum[7:0]);
    m17_byte  = m17_fold[7:0] + 8'(m17_fold[8]);
    key_mod17 = oah_pkg::DH_W'(m17_byte[3:0]) - oah_pkg::DH_W'(m17_byte[7:4]);
    if (key_mod17[oah_pkg::DH_W-1]) begin
      key_mod17 = key_mod17 + oah_pkg::DH_W'(oah_pkg::DH_PRIME);
    end
  end

  assign idx_next = oah_pkg::IDX_W'(mod_add(oah_pkg::SIZE_W'(idx_q), step_sel, eff_size));
  assign dh_step  = oah_pkg::DH_W'(oah_pkg::DH_PRIME) - key_mod17;
  assign k3       = (TW'(k_q) << 1) + TW'(k_q);
  assign hit      = (rd_q == key_q);
  assign empty    = (rd_q == '0);
  assign out_free = !out_valid_q || out_o.ready;

  // slot memory: one write port, one registered read port
  assign rd_addr   = (state_q == S_NEXT) ? idx_next : idx_q;
  assign mem_we    = (state_q == S_CLEAR) || ((state_q == S_CMP) && !hit && empty);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
  assign mem_wdata = (state_q == S_CLEAR) ? '0 : key_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_mode_q <= oah_pkg::MODE_LINEAR;
      table_size_q <= oah_pkg::CFG_W'(1019);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        oah_pkg::CFG_PROBE_MODE: probe_mode_q <= cfg_data_i[oah_pkg::MODE_W-1:0];
        oah_pkg::CFG_TABLE_SIZE: table_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      occ_q        <= '0;
      key_q        <= '0;
      idx_q        <= '0;
      k_q          <= '0;
      sq_q         <= '0;
      d_q          <= '0;
      step_q       <= '0;
      div_req_q    <= '0;
      res_status_q <= '0;
      res_slot_q   <= '0;
      res_count_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_count_q  <= '0;
      out_entry_q  <= '0;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + oah_pkg::IDX_W'(1);
          if (clr_q == oah_pkg::IDX_W'(oah_pkg::TABLE_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_i.valid) begin
            key_q <= in_i.key;
            if (in_i.key == '0) begin
              res_status_q <= oah_pkg::ST_FULL;
              res_slot_q   <= '0;
              res_count_q  <= '0;
              state_q      <= S_FIN;
            end else begin
              div_req_q.start    <= 1'b1;
              div_req_q.dividend <= in_i.key;
              div_req_q.divisor  <= oah_pkg::DIV_W'(eff_size);
              state_q            <= S_DIV_HOME;
            end
          end
        end

        S_DIV_HOME: begin
          if (div_rsp.done) begin
            idx_q <= oah_pkg::IDX_W'(div_rsp.rem);
            k_q   <= '0;
            sq_q  <= one_m;
            d_q   <= three_m;
            if (probe_mode_q == oah_pkg::MODE_NONE) begin
              res_status_q <= oah_pkg::ST_FULL;
              res_slot_q   <= oah_pkg::IDX_W'(div_rsp.rem);
              res_count_q  <= '0;
              state_q      <= S_FIN;
            end else if (probe_mode_q == oah_pkg::MODE_DOUBLE) begin
              // double-hash step 17 - key mod 17, reduced mod size
              div_req_q.start    <= 1'b1;
              div_req_q.dividend <= oah_pkg::KEY_W'(dh_step);
              div_req_q.divisor  <= oah_pkg::DIV_W'(eff_size);
              state_q            <= S_DIV_STEP;
            end else begin
              state_q <= S_READ;
            end
          end
        end

        S_DIV_STEP: begin
          if (div_rsp.done) begin
            step_q  <= oah_pkg::SIZE_W'(div_rsp.rem);
            state_q <= S_READ;
          end
        end

        S_READ: begin
          state_q <= S_CMP;
        end

        S_CMP: begin
          res_slot_q <= idx_q;
          if (hit) begin
            res_status_q <= oah_pkg::ST_DUPLICATE;
            res_count_q  <= (k_q == '0) ? oah_pkg::COUNT_W'(1) : sat_count(k3 - TW'(1));
            state_q      <= S_FIN;
          end else if (empty) begin
            res_status_q <= oah_pkg::ST_INSERTED;
            res_count_q  <= (k_q == '0) ? oah_pkg::COUNT_W'(1) : sat_count(k3);
            occ_q        <= occ_q + oah_pkg::SIZE_W'(1);
            state_q      <= S_FIN;
          end else if ((k_q != '0) && (k_q >= eff_size)) begin
            res_status_q <= oah_pkg::ST_FULL;
            res_count_q  <= sat_count(k3 + TW'(1));
            state_q      <= S_FIN;
          end else begin
            state_q <= S_NEXT;
          end
        end

        // advance to probe k+1; the read of the new slot issues this cycle
        S_NEXT: begin
          idx_q   <= idx_next;
          k_q     <= k_q + oah_pkg::SIZE_W'(1);
          sq_q    <= mod_add(sq_q, d_q, eff_size);
          d_q     <= mod_add(mod_add(d_q, oah_pkg::SIZE_W'(1), eff_size),
                             oah_pkg::SIZE_W'(1), eff_size);
          state_q <= S_CMP;
        end

        S_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_slot_q   <= res_slot_q;
            out_count_q  <= res_count_q;
            out_entry_q  <= occ_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.slot        = out_slot_q;
  assign out_o.probe_count = out_count_q;
  assign out_o.entry_count = out_entry_q;

endmodule
